>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the orbit engine RTL.
// Depends on nothing; included by files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`endif

>>> hw/rtl/opp_pkg.sv
// Shared types and constants of the orbit polar position engine.
// Depends on nothing; used by the controller, datapath and top level.
package opp_pkg;
    localparam logic [31:0] GAIN_K = 32'd652032874;

    localparam logic [1:0] REG_CENTER_X = 2'd0;
    localparam logic [1:0] REG_CENTER_Y = 2'd1;
    localparam logic [1:0] REG_BODY_COUNT = 2'd2;

    localparam logic [2:0] DP_NONE = 3'd0;
    localparam logic [2:0] DP_LOAD_INIT = 3'd1;
    localparam logic [2:0] DP_MOVE_READ = 3'd2;
    localparam logic [2:0] DP_MOVE_MUL = 3'd3;
    localparam logic [2:0] DP_MOVE_INIT = 3'd4;
    localparam logic [2:0] DP_STEP = 3'd5;
    localparam logic [2:0] DP_GAIN = 3'd6;
    localparam logic [2:0] DP_EMIT = 3'd7;

    typedef struct packed {
        logic [2:0] cmd;
        logic       mode_move;
        logic       last;
    } dp_cmd_t;

    typedef struct packed {
        logic steps_done;
        logic gain_done;
    } dp_status_t;

    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] r;
        begin
            case (i)
                5'd0: r = 32'h20000000; 5'd1: r = 32'h12E4051E;
                5'd2: r = 32'h09FB385B; 5'd3: r = 32'h051111D4;
                5'd4: r = 32'h028B0D43; 5'd5: r = 32'h0145D7E1;
                5'd6: r = 32'h00A2F61E; 5'd7: r = 32'h00517C55;
                5'd8: r = 32'h0028BE53; 5'd9: r = 32'h00145F2F;
                5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
                5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3;
                5'd14: r = 32'h0000A2FA; 5'd15: r = 32'h0000517D;
                5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
                5'd18: r = 32'h00000A30; 5'd19: r = 32'h00000518;
                5'd20: r = 32'h0000028C; 5'd21: r = 32'h00000146;
                5'd22: r = 32'h000000A3; 5'd23: r = 32'h00000051;
                5'd24: r = 32'h00000029; 5'd25: r = 32'h00000014;
                5'd26: r = 32'h0000000A; 5'd27: r = 32'h00000005;
                5'd28: r = 32'h00000003; 5'd29: r = 32'h00000001;
                5'd30: r = 32'h00000001;
                default: r = 32'h00000000;
            endcase
            return r;
        end
    endfunction
endpackage

>>> hw/rtl/opp_datapath.sv
// Datapath of the orbit engine: body tables, shared CORDIC unit, gain multiplier.
// Depends on opp_pkg; driven by opp_controller.
module opp_datapath #(
    parameter int MAX_BODIES = 16,
    parameter int CORDIC_STEPS = 24,
    parameter int IW = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  opp_pkg::dp_cmd_t    cmd,
    output opp_pkg::dp_status_t status,
    input  logic [3:0]          body_index,
    input  logic [3:0]          move_index,
    input  logic signed [31:0]  start_x,
    input  logic signed [31:0]  start_y,
    input  logic [31:0]         angular_speed,
    input  logic [23:0]         time_value,
    input  logic signed [31:0]  center_x,
    input  logic signed [31:0]  center_y,
    output logic                done,
    output logic [3:0]          result_index,
    output logic signed [31:0]  pos_x,
    output logic signed [31:0]  pos_y,
    output logic [31:0]         radius,
    output logic [31:0]         angle,
    output logic                last
);
    localparam int NSTEP = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
    localparam int DEPTH = MAX_BODIES;

    logic [31:0] rad_mem [DEPTH];
    logic [31:0] ang_mem [DEPTH];
    logic [31:0] spd_mem [DEPTH];

    // CORDIC registers, 36 bits cover the vectoring growth of a 33-bit offset.
    logic signed [35:0] x_reg, x_next, y_reg, y_next;
    logic [31:0] z_reg, z_next;
    logic [4:0]  i_reg, i_next;
    logic        flip_reg, flip_next, zero_reg, zero_next;
    logic [1:0]  g_reg, g_next;
    logic [63:0] p_reg, p_next;
    logic [31:0] rr_reg, ra_reg, rs_reg, ang_reg, ang_next;
    logic [23:0] t_reg;
    logic [3:0]  idx_reg, idx_next;
    logic signed [31:0] sx_reg, sx_next, sy_reg, sy_next;
    logic [31:0] rad_reg, rad_next;
    logic        done_reg, done_next, last_reg, last_next;
    logic signed [31:0] ox_reg, ox_next, oy_reg, oy_next;

    logic signed [32:0] dx, dy;
    logic signed [35:0] tx, ty;
    logic [31:0] at;
    logic        vdir;
    logic [63:0] mul;
    logic [31:0] ra_flip;
    logic signed [35:0] fx, fy;
    logic signed [36:0] sumx, sumy;
    logic [31:0] prod_t;

    function automatic logic signed [31:0] sat(input logic signed [36:0] v);
        begin
            if (v > 37'sd2147483647) return 32'sh7FFFFFFF;
            else if (v < -37'sd2147483648) return 32'sh80000000;
            else return v[31:0];
        end
    endfunction

    assign dx = 33'(start_x) - 33'(center_x);
    assign dy = 33'(start_y) - 33'(center_y);
    assign tx = x_reg >>> i_reg;
    assign ty = y_reg >>> i_reg;
    assign at = opp_pkg::atan_turn(i_reg);
    assign vdir = cmd.mode_move ? !z_reg[31] : !y_reg[35];
    assign prod_t = rs_reg * {8'd0, t_reg};
    assign ra_flip = ang_reg + 32'h40000000;
    assign fx = flip_reg ? -x_reg : x_reg;
    assign fy = flip_reg ? -y_reg : y_reg;
    assign sumx = 37'(center_x) + 37'(fx);
    assign sumy = 37'(center_y) + 37'(fy);

    // Gain multiply: a load splits it into two partial products (upper, lower x bits times GAIN_K).
    always_comb
    begin
        if (cmd.mode_move)
            mul = {32'd0, rr_reg} * {32'd0, opp_pkg::GAIN_K};
        else if (g_reg == 2'd0)
            mul = {32'd0, x_reg[35] ? 32'd0 : 32'(x_reg[35:16])} * {32'd0, opp_pkg::GAIN_K};
        else
            mul = {48'd0, x_reg[35] ? 16'd0 : x_reg[15:0]} * {32'd0, opp_pkg::GAIN_K};
    end

    always_comb
    begin
        x_next = x_reg; y_next = y_reg; z_next = z_reg; i_next = i_reg;
        flip_next = flip_reg; zero_next = zero_reg; g_next = g_reg; p_next = p_reg;
        ang_next = ang_reg; idx_next = idx_reg; sx_next = sx_reg; sy_next = sy_reg;
        rad_next = rad_reg; done_next = 1'b0; last_next = last_reg;
        ox_next = ox_reg; oy_next = oy_reg;
        case (cmd.cmd)
            opp_pkg::DP_LOAD_INIT:
            begin
                zero_next = (dx == 33'sd0) && (dy == 33'sd0);
                x_next = dx[32] ? -36'(dx) : 36'(dx);
                y_next = dx[32] ? -36'(dy) : 36'(dy);
                z_next = dx[32] ? 32'h80000000 : 32'd0;
                i_next = 5'd0; g_next = 2'd0; p_next = 64'd0;
                idx_next = body_index; sx_next = start_x; sy_next = start_y;
            end
            opp_pkg::DP_MOVE_READ: idx_next = move_index;
            opp_pkg::DP_MOVE_MUL: ang_next = ra_reg + prod_t;
            opp_pkg::DP_MOVE_INIT:
            begin
                flip_next = ra_flip[31];
                z_next = ra_flip[31] ? ang_reg + 32'h80000000 : ang_reg;
                x_next = 36'(mul[61:30]);
                y_next = 36'sd0; i_next = 5'd0;
            end
            opp_pkg::DP_STEP:
            begin
                if (vdir)
                begin
                    x_next = cmd.mode_move ? x_reg - ty : x_reg + ty;
                    y_next = cmd.mode_move ? y_reg + tx : y_reg - tx;
                    z_next = cmd.mode_move ? z_reg - at : z_reg + at;
                end
                else
                begin
                    x_next = cmd.mode_move ? x_reg + ty : x_reg - ty;
                    y_next = cmd.mode_move ? y_reg - tx : y_reg + tx;
                    z_next = cmd.mode_move ? z_reg + at : z_reg - at;
                end
                i_next = i_reg + 5'd1;
            end
            opp_pkg::DP_GAIN:
            begin
                if (g_reg == 2'd0) p_next = mul;
                else p_next = (p_reg + (mul >> 16)) >> 14;
                g_next = g_reg + 2'd1;
            end
            opp_pkg::DP_EMIT:
            begin
                done_next = 1'b1; last_next = cmd.last;
                if (cmd.mode_move)
                begin
                    ox_next = sat(sumx); oy_next = sat(sumy);
                    rad_next = rr_reg; ang_next = ang_reg;
                end
                else
                begin
                    ox_next = sx_reg; oy_next = sy_reg;
                    rad_next = zero_reg ? 32'd0 : (|p_reg[63:32] ? 32'hFFFFFFFF : p_reg[31:0]);
                    ang_next = zero_reg ? 32'd0 : z_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= done_next;
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next; y_reg <= y_next; z_reg <= z_next; i_reg <= i_next;
        flip_reg <= flip_next; zero_reg <= zero_next; g_reg <= g_next; p_reg <= p_next;
        ang_reg <= ang_next; idx_reg <= idx_next; sx_reg <= sx_next; sy_reg <= sy_next;
        rad_reg <= rad_next; last_reg <= last_next; ox_reg <= ox_next; oy_reg <= oy_next;
        // The controller only idles between requests, so the last idle edge is the accept.
        if (cmd.cmd == opp_pkg::DP_NONE)
            t_reg <= time_value;
        if (cmd.cmd == opp_pkg::DP_EMIT && !cmd.mode_move && 32'(idx_reg) < DEPTH)
        begin
            rad_mem[IW'(idx_reg)] <= rad_next;
            ang_mem[IW'(idx_reg)] <= ang_next;
            spd_mem[IW'(idx_reg)] <= rs_reg;
        end
        if (cmd.cmd == opp_pkg::DP_LOAD_INIT)
            rs_reg <= angular_speed;
        else if (cmd.cmd == opp_pkg::DP_MOVE_READ)
        begin
            rr_reg <= rad_mem[IW'(move_index)];
            ra_reg <= ang_mem[IW'(move_index)];
            rs_reg <= spd_mem[IW'(move_index)];
        end
    end

    assign status.steps_done = (i_reg == 5'(NSTEP - 1)) && (cmd.cmd == opp_pkg::DP_STEP);
    assign status.gain_done = (g_reg == 2'd1);
    assign done = done_reg;
    assign result_index = idx_reg;
    assign pos_x = ox_reg;
    assign pos_y = oy_reg;
    assign radius = rad_reg;
    assign angle = ang_reg;
    assign last = last_reg;
endmodule

>>> hw/rtl/opp_controller.sv
// Controller of the orbit engine: sequences load and move items.
// Depends on opp_pkg and assert_macros.svh; drives opp_datapath.
`include "assert_macros.svh"
module opp_controller #(
    parameter int MAX_BODIES = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                op,
    input  logic [4:0]          body_count,
    input  opp_pkg::dp_status_t status,
    output opp_pkg::dp_cmd_t    cmd,
    output logic [3:0]          move_index,
    output logic                busy
);
    localparam logic [2:0] S_IDLE = 3'd0, S_READ = 3'd1, S_MUL = 3'd2, S_INIT = 3'd3;
    localparam logic [2:0] S_STEP = 3'd4, S_GAIN = 3'd5, S_EMIT = 3'd6;
    localparam int LIM = (MAX_BODIES < 16) ? MAX_BODIES : 16;

    logic [2:0] state_reg, state_next;
    logic       move_reg, move_next;
    logic [4:0] n_reg, n_next, k_reg, k_next;

    always_comb
    begin
        state_next = state_reg; move_next = move_reg; n_next = n_reg; k_next = k_reg;
        cmd.cmd = opp_pkg::DP_NONE;
        cmd.mode_move = move_reg;
        cmd.last = (k_reg + 5'd1 == n_reg) || !move_reg;
        case (state_reg)
            S_IDLE:
                if (start)
                begin
                    move_next = op; k_next = 5'd0;
                    n_next = (32'(body_count) > LIM) ? 5'(LIM) : body_count;
                    if (!op)
                    begin
                        cmd.cmd = opp_pkg::DP_LOAD_INIT; state_next = S_STEP;
                    end
                    else if (body_count != 5'd0)
                        state_next = S_READ;
                end
            S_READ: begin cmd.cmd = opp_pkg::DP_MOVE_READ; state_next = S_MUL; end
            S_MUL: begin cmd.cmd = opp_pkg::DP_MOVE_MUL; state_next = S_INIT; end
            S_INIT: begin cmd.cmd = opp_pkg::DP_MOVE_INIT; state_next = S_STEP; end
            S_STEP:
            begin
                cmd.cmd = opp_pkg::DP_STEP;
                if (status.steps_done) state_next = move_reg ? S_EMIT : S_GAIN;
            end
            S_GAIN:
            begin
                cmd.cmd = opp_pkg::DP_GAIN;
                if (status.gain_done) state_next = S_EMIT;
            end
            S_EMIT:
            begin
                cmd.cmd = opp_pkg::DP_EMIT;
                if (cmd.last) state_next = S_IDLE;
                else
                begin
                    k_next = k_reg + 5'd1; state_next = S_READ;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE; move_reg <= 1'b0; n_reg <= 5'd0; k_reg <= 5'd0;
        end
        else
        begin
            state_reg <= state_next; move_reg <= move_next;
            n_reg <= n_next; k_reg <= k_next;
        end
    end

    assign move_index = k_reg[3:0];
    assign busy = (state_reg != S_IDLE);

    `ASSERT_IMPL(a_emit_busy, clk, rst_n, cmd.cmd == opp_pkg::DP_EMIT, busy, "emit while idle")
    `ASSERT_IMPL(a_k_bound, clk, rst_n, busy && move_reg, k_reg < n_reg, "body index past count")
    `ASSERT_NEXT(a_emit_next, clk, rst_n, cmd.cmd == opp_pkg::DP_EMIT && !cmd.last,
        state_reg == S_READ, "move did not continue")
endmodule

>>> hw/rtl/orbit_polar_position_engine.sv
// A load runs its init, the CORDIC steps, the two-part gain multiply and the emit.
// A move runs read, time multiply, init, CORDIC steps and emit for each body in turn,
// through the shared CORDIC unit, for min(body_count, MAX_BODIES, 16) bodies.
// busy stays high until the last result; results are one-cycle strobes.
// Reset (rst_n low, asynchronous) clears control, config and result_valid; tables unset.
module orbit_polar_position_engine #(
    parameter int MAX_BODIES = 16,
    parameter int CORDIC_STEPS = 24
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               op,
    input  logic [3:0]         body_index,
    input  logic signed [31:0] start_x,
    input  logic signed [31:0] start_y,
    input  logic signed [31:0] angular_speed,
    input  logic [23:0]        time_value,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output logic               result_valid,
    output logic [3:0]         result_index,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic [31:0]        radius,
    output logic [31:0]        angle,
    output logic               last
);
    logic signed [31:0] center_x_reg, center_y_reg;
    logic [4:0] body_count_reg;
    opp_pkg::dp_cmd_t cmd;
    opp_pkg::dp_status_t status;
    logic [3:0] move_index;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= '0; center_y_reg <= '0; body_count_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                opp_pkg::REG_CENTER_X: center_x_reg <= cfg_data;
                opp_pkg::REG_CENTER_Y: center_y_reg <= cfg_data;
                opp_pkg::REG_BODY_COUNT: body_count_reg <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    opp_controller #(.MAX_BODIES(MAX_BODIES)) u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .op(op), .body_count(body_count_reg),
        .status(status), .cmd(cmd), .move_index(move_index), .busy(busy)
    );

    opp_datapath #(.MAX_BODIES(MAX_BODIES), .CORDIC_STEPS(CORDIC_STEPS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .status(status), .body_index(body_index),
        .move_index(move_index), .start_x(start_x), .start_y(start_y),
        .angular_speed(angular_speed), .time_value(time_value),
        .center_x(center_x_reg), .center_y(center_y_reg), .done(result_valid),
        .result_index(result_index), .pos_x(pos_x), .pos_y(pos_y), .radius(radius),
        .angle(angle), .last(last)
    );
endmodule
